// File: rtl/imu_sie_pkg.sv
// Shared types, constants and helper functions of the IMU static initialization estimator.
package imu_sie_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int IN_BITS     = 32;
   localparam int SAMPLE_BITS = 40;
   localparam int WORD_BITS   = 48;
   localparam int VAR_BITS    = 47;
   localparam int SQ_BITS     = 60;
   localparam int GRAV_BITS   = 24;
   localparam int MIN_BITS    = 16;
   localparam int CSR_BITS    = 24;
   localparam int RATIO_BITS  = 41;
   localparam int NUM_AXES    = 6;
   localparam int AXIS_BITS   = 3;
   localparam int NUM_ACC     = 3;

   localparam int MUL_A_BITS   = 64;
   localparam int MUL_B_BITS   = 48;
   localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int MUL_CNT_BITS = $clog2(MUL_B_BITS);

   localparam int DIV_N_BITS   = 64;
   localparam int DIV_D_BITS   = 32;
   localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS);

   localparam int SQRT_X_BITS   = 64;
   localparam int SQRT_R_BITS   = 32;
   localparam int SQRT_REM_BITS = SQRT_R_BITS + 2;
   localparam int SQRT_CNT_BITS = $clog2(SQRT_R_BITS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;
   localparam logic [VAR_BITS-1:0]   VAR_MAX         = '1;
   localparam logic [GRAV_BITS-1:0]  GRAVITY_RESET   = 24'd642908;
   localparam logic [MIN_BITS-1:0]   MIN_COUNT_RESET = 16'd20;

   localparam logic CSR_GRAVITY   = 1'b0;
   localparam logic CSR_MIN_COUNT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_DIV,
      ST_SQ_MUL,
      ST_KEEP_DIV,
      ST_CEIL_DIV,
      ST_TERM_DIV,
      ST_CHECK,
      ST_NORM_MUL,
      ST_SQRT,
      ST_RATIO_DIV,
      ST_GRAV_MUL,
      ST_GRAV_DIV,
      ST_VAR_MUL1,
      ST_VAR_MUL2,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      KIND_STATUS,
      KIND_GRAVITY,
      KIND_BIAS,
      KIND_ACC_VAR,
      KIND_GYR_VAR
   } kind_type;

   // Rounds a product of a variance and a Q16.16 ratio back to Q24.24 and saturates.
   function automatic logic [VAR_BITS-1:0] round_sat(input logic [MUL_P_BITS-1:0] p);
      logic [MUL_P_BITS-1:0] t;
      t = p + MUL_P_BITS'(32768);
      if (t[MUL_P_BITS-1:VAR_BITS+16] != '0) begin
         round_sat = VAR_MAX;
      end else begin
         round_sat = t[VAR_BITS+15:16];
      end
   endfunction

endpackage

// File: rtl/imu_sie_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module imu_sie_mul
   import imu_sie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [MUL_A_BITS-1:0] a,
   input  logic [MUL_B_BITS-1:0] b,
   output logic                  done,
   output logic [MUL_P_BITS-1:0] product
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MUL_A_BITS-1:0]   a_ff, a_in;
   logic [MUL_P_BITS-1:0]   acc_ff, acc_in;
   logic [MUL_A_BITS:0]     sum;

   always_comb begin
      sum = {1'b0, acc_ff[MUL_P_BITS-1:MUL_B_BITS]}
            + (acc_ff[0] ? {1'b0, a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         acc_in  = {{MUL_A_BITS{1'b0}}, b};
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[MUL_B_BITS-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_BITS'(MUL_B_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/imu_sie_div.sv
// Restoring divider that produces one quotient bit per cycle.
module imu_sie_div
   import imu_sie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_N_BITS-1:0] numer,
   input  logic [DIV_D_BITS-1:0] denom,
   output logic                  done,
   output logic [DIV_N_BITS-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_D_BITS-1:0]   den_ff, den_in;
   logic [DIV_D_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_N_BITS-1:0]   quo_ff, quo_in;
   logic [DIV_D_BITS:0]     trial;
   logic [DIV_D_BITS:0]     diff;
   logic                    fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_N_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
         quo_in = {quo_ff[DIV_N_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_N_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/imu_sie_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module imu_sie_sqrt
   import imu_sie_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SQRT_X_BITS-1:0] radicand,
   output logic                   done,
   output logic [SQRT_R_BITS-1:0] root
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [SQRT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SQRT_X_BITS-1:0]   rad_ff, rad_in;
   logic [SQRT_REM_BITS-1:0] rem_ff, rem_in;
   logic [SQRT_R_BITS-1:0]   root_ff, root_in;
   logic [SQRT_REM_BITS+1:0] shifted;
   logic [SQRT_REM_BITS+1:0] trial;
   logic [SQRT_REM_BITS+1:0] diff;
   logic                     fits;

   always_comb begin
      shifted = {rem_ff, rad_ff[SQRT_X_BITS-1:SQRT_X_BITS-2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      fits    = shifted >= trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[SQRT_REM_BITS-1:0] : shifted[SQRT_REM_BITS-1:0];
         root_in = {root_ff[SQRT_R_BITS-2:0], fits};
         rad_in  = {rad_ff[SQRT_X_BITS-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CNT_BITS'(SQRT_R_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/imu_static_init_estimator.sv
// Top level of the IMU static initialization estimator: sequencer, state and result register.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    six Q16.16 axes and frame_end
//   rsp      out        rsp_valid/rsp_ready    kind, three Q24.24 values, count and flags
//   csr      in         csr_valid/csr_ready    register index and write data
//
// For a sample, each of the six axes runs four serial divisions and one serial multiplication,
// all on one shared divider and one multiplier.
// A completing sample adds the norm, ratio, gravity and scaling steps.
// Once initialization has finished, a sample goes straight to the emit step and yields a status transfer.
// Reset restores the register defaults and clears the count, means and variances.
// A stalled result channel holds the sequencer in its emit step until each transfer completes.
module imu_static_init_estimator
   import imu_sie_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [IN_BITS-1:0] req_acc_x,
   input  logic signed [IN_BITS-1:0] req_acc_y,
   input  logic signed [IN_BITS-1:0] req_acc_z,
   input  logic signed [IN_BITS-1:0] req_gyr_x,
   input  logic signed [IN_BITS-1:0] req_gyr_y,
   input  logic signed [IN_BITS-1:0] req_gyr_z,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_vector_kind,
   output logic signed [WORD_BITS-1:0] rsp_value_x,
   output logic signed [WORD_BITS-1:0] rsp_value_y,
   output logic signed [WORD_BITS-1:0] rsp_value_z,
   output logic [COUNT_BITS-1:0]  rsp_samples_seen,
   output logic                   rsp_init_done,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CSR_BITS-1:0]    csr_data
);

   state_type              state_ff, state_in;
   logic                   go_ff, go_in;
   logic [AXIS_BITS-1:0]   axis_ff, axis_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   finished_ff, finished_in;
   logic [GRAV_BITS-1:0]   gravity_ff, gravity_in;
   logic [MIN_BITS-1:0]    min_ff, min_in;
   logic [SAMPLE_BITS-1:0] sample_ff [NUM_AXES];
   logic [SAMPLE_BITS-1:0] sample_in [NUM_AXES];
   logic                   frame_ff, frame_in;
   logic [WORD_BITS-1:0]   mean_ff [NUM_AXES];
   logic [WORD_BITS-1:0]   mean_in [NUM_AXES];
   logic [VAR_BITS-1:0]    var_ff [NUM_AXES];
   logic [VAR_BITS-1:0]    var_in [NUM_AXES];
   logic [VAR_BITS-1:0]    keep_ff, keep_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;
   logic [SQRT_X_BITS-1:0] sum_ff, sum_in;
   logic [SQRT_R_BITS-1:0] norm_ff, norm_in;
   logic [RATIO_BITS-1:0]  ratio_ff, ratio_in;
   logic [WORD_BITS-1:0]   grav_ff [NUM_ACC];
   logic [WORD_BITS-1:0]   grav_in [NUM_ACC];
   kind_type               kind_ff, kind_in;
   logic                   multi_ff, multi_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [WORD_BITS-1:0]   rsp_x_ff, rsp_x_in;
   logic [WORD_BITS-1:0]   rsp_y_ff, rsp_y_in;
   logic [WORD_BITS-1:0]   rsp_z_ff, rsp_z_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_fire;
   logic                   out_load;
   logic                   emit_last;
   logic                   complete;
   logic                   unit_done;
   logic                   is_unit;
   logic [WORD_BITS-1:0]   cur;
   logic [WORD_BITS-1:0]   dev;
   logic [WORD_BITS-1:0]   dev_mag;
   logic [WORD_BITS-1:0]   mean_mag;
   logic [SQ_BITS:0]       var_sum;
   logic [WORD_BITS-1:0]   gq;

   logic                   mul_start, mul_done;
   logic [MUL_A_BITS-1:0]  mul_a;
   logic [MUL_B_BITS-1:0]  mul_b;
   logic [MUL_P_BITS-1:0]  mul_prod;
   logic                   div_start, div_done;
   logic [DIV_N_BITS-1:0]  div_num;
   logic [DIV_D_BITS-1:0]  div_den;
   logic [DIV_N_BITS-1:0]  div_quo;
   logic                   sqrt_start, sqrt_done;
   logic [SQRT_R_BITS-1:0] sqrt_root;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign out_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = !multi_ff || (kind_ff == KIND_GYR_VAR);
   assign complete  = frame_ff
                      && (({1'b0, count_ff} + 1'b1) > {1'b0, min_ff});
   assign unit_done = mul_done || div_done || sqrt_done;

   assign cur      = {{(WORD_BITS-SAMPLE_BITS){sample_ff[axis_ff][SAMPLE_BITS-1]}},
                      sample_ff[axis_ff]};
   assign dev      = cur - mean_ff[axis_ff];
   assign dev_mag  = dev[WORD_BITS-1] ? (~dev + 1'b1) : dev;
   assign mean_mag = mean_ff[axis_ff][WORD_BITS-1] ? (~mean_ff[axis_ff] + 1'b1)
                                                   : mean_ff[axis_ff];
   assign var_sum  = {{(SQ_BITS+1-VAR_BITS){1'b0}}, keep_ff}
                     + {1'b0, div_quo[SQ_BITS-1:0]};
   assign gq       = div_quo[WORD_BITS-1:0];

   always_comb begin
      case (state_ff)
         ST_MEAN_DIV, ST_SQ_MUL, ST_KEEP_DIV, ST_CEIL_DIV, ST_TERM_DIV, ST_NORM_MUL,
         ST_SQRT, ST_RATIO_DIV, ST_GRAV_MUL, ST_GRAV_DIV, ST_VAR_MUL1, ST_VAR_MUL2: begin
            is_unit = 1'b1;
         end
         default: begin
            is_unit = 1'b0;
         end
      endcase
      mul_start  = go_ff && ((state_ff == ST_SQ_MUL) || (state_ff == ST_NORM_MUL)
                   || (state_ff == ST_GRAV_MUL) || (state_ff == ST_VAR_MUL1)
                   || (state_ff == ST_VAR_MUL2));
      div_start  = go_ff && ((state_ff == ST_MEAN_DIV) || (state_ff == ST_KEEP_DIV)
                   || (state_ff == ST_CEIL_DIV) || (state_ff == ST_TERM_DIV)
                   || (state_ff == ST_RATIO_DIV) || (state_ff == ST_GRAV_DIV));
      sqrt_start = go_ff && (state_ff == ST_SQRT);
   end

   always_comb begin
      mul_a   = {{(MUL_A_BITS-WORD_BITS){1'b0}}, dev_mag};
      mul_b   = dev_mag;
      div_num = {{(DIV_N_BITS-WORD_BITS){1'b0}}, dev_mag}
                + {{(DIV_N_BITS-COUNT_BITS+1){1'b0}}, count_ff[COUNT_BITS-1:1]};
      div_den = {{(DIV_D_BITS-COUNT_BITS){1'b0}}, count_ff};
      case (state_ff)
         ST_NORM_MUL: begin
            mul_a = {{(MUL_A_BITS-32){1'b0}}, mean_mag[39:8]};
            mul_b = {{(MUL_B_BITS-32){1'b0}}, mean_mag[39:8]};
         end
         ST_GRAV_MUL: begin
            mul_a = {{(MUL_A_BITS-WORD_BITS){1'b0}}, mean_mag};
            mul_b = {{(MUL_B_BITS-GRAV_BITS){1'b0}}, gravity_ff};
         end
         ST_VAR_MUL1, ST_VAR_MUL2: begin
            mul_a = {{(MUL_A_BITS-VAR_BITS){1'b0}}, var_ff[axis_ff]};
            mul_b = {{(MUL_B_BITS-RATIO_BITS){1'b0}}, ratio_ff};
         end
         ST_KEEP_DIV: begin
            div_num = {{(DIV_N_BITS-VAR_BITS){1'b0}}, var_ff[axis_ff]}
                      + {{(DIV_N_BITS-COUNT_BITS){1'b0}}, count_ff} - 1'b1;
         end
         ST_CEIL_DIV: begin
            div_num = {{(DIV_N_BITS-SQ_BITS){1'b0}}, sq_ff}
                      + {{(DIV_N_BITS-COUNT_BITS){1'b0}}, count_ff} - 1'b1;
         end
         ST_TERM_DIV: begin
            div_num = {{(DIV_N_BITS-SQ_BITS){1'b0}}, sq_ff};
         end
         ST_RATIO_DIV: begin
            div_num = {{(DIV_N_BITS-GRAV_BITS-16){1'b0}}, gravity_ff, 16'h0000}
                      + {{(DIV_N_BITS-SQRT_R_BITS+1){1'b0}}, norm_ff[SQRT_R_BITS-1:1]};
            div_den = norm_ff;
         end
         ST_GRAV_DIV: begin
            div_num = mul_prod[DIV_N_BITS-1:0]
                      + {{(DIV_N_BITS-SQRT_R_BITS+1){1'b0}}, norm_ff[SQRT_R_BITS-1:1]};
            div_den = norm_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = finished_ff ? ST_EMIT : ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            if (div_done) begin
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            if (mul_done) begin
               state_in = ST_KEEP_DIV;
            end
         end
         ST_KEEP_DIV: begin
            if (div_done) begin
               state_in = ST_CEIL_DIV;
            end
         end
         ST_CEIL_DIV: begin
            if (div_done) begin
               state_in = ST_TERM_DIV;
            end
         end
         ST_TERM_DIV: begin
            if (div_done) begin
               state_in = (axis_ff == AXIS_BITS'(NUM_AXES - 1)) ? ST_CHECK : ST_MEAN_DIV;
            end
         end
         ST_CHECK: begin
            state_in = complete ? ST_NORM_MUL : ST_EMIT;
         end
         ST_NORM_MUL: begin
            if (mul_done) begin
               state_in = (axis_ff == AXIS_BITS'(NUM_ACC - 1)) ? ST_SQRT : ST_NORM_MUL;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = (sqrt_root == '0) ? ST_EMIT : ST_RATIO_DIV;
            end
         end
         ST_RATIO_DIV: begin
            if (div_done) begin
               state_in = ST_GRAV_MUL;
            end
         end
         ST_GRAV_MUL: begin
            if (mul_done) begin
               state_in = ST_GRAV_DIV;
            end
         end
         ST_GRAV_DIV: begin
            if (div_done) begin
               state_in = (axis_ff == AXIS_BITS'(NUM_ACC - 1)) ? ST_VAR_MUL1 : ST_GRAV_MUL;
            end
         end
         ST_VAR_MUL1: begin
            if (mul_done) begin
               state_in = ST_VAR_MUL2;
            end
         end
         ST_VAR_MUL2: begin
            if (mul_done) begin
               state_in = (axis_ff == AXIS_BITS'(NUM_ACC - 1)) ? ST_EMIT : ST_VAR_MUL1;
            end
         end
         ST_EMIT: begin
            if (out_load && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      go_in        = 1'b0;
      axis_in      = axis_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      gravity_in   = gravity_ff;
      min_in       = min_ff;
      sample_in    = sample_ff;
      frame_in     = frame_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      keep_in      = keep_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      norm_in      = norm_ff;
      ratio_in     = ratio_ff;
      grav_in      = grav_ff;
      kind_in      = kind_ff;
      multi_in     = multi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_count_in = rsp_count_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;

      if (is_unit) begin
         go_in = 1'b0;
      end
      case (state_in)
         ST_MEAN_DIV, ST_SQ_MUL, ST_KEEP_DIV, ST_CEIL_DIV, ST_TERM_DIV, ST_NORM_MUL,
         ST_SQRT, ST_RATIO_DIV, ST_GRAV_MUL, ST_GRAV_DIV, ST_VAR_MUL1, ST_VAR_MUL2: begin
            go_in = unit_done || (state_ff == ST_IDLE) || (state_ff == ST_CHECK);
         end
         default: begin
            go_in = 1'b0;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRAVITY: begin
               gravity_in = csr_data;
            end
            CSR_MIN_COUNT: begin
               min_in = csr_data[MIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = KIND_STATUS;
               multi_in = 1'b0;
               if (!finished_ff) begin
                  sample_in[0] = {req_acc_x, 8'h00};
                  sample_in[1] = {req_acc_y, 8'h00};
                  sample_in[2] = {req_acc_z, 8'h00};
                  sample_in[3] = {req_gyr_x, 8'h00};
                  sample_in[4] = {req_gyr_y, 8'h00};
                  sample_in[5] = {req_gyr_z, 8'h00};
                  frame_in     = req_frame_end;
                  count_in     = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 1'b1;
                  axis_in      = '0;
               end
            end
         end
         ST_MEAN_DIV: begin
            if (div_done) begin
               mean_in[axis_ff] = dev[WORD_BITS-1] ? mean_ff[axis_ff] - gq
                                                   : mean_ff[axis_ff] + gq;
            end
         end
         ST_SQ_MUL: begin
            if (mul_done) begin
               sq_in = mul_prod[SQ_BITS+23:24];
            end
         end
         ST_KEEP_DIV: begin
            if (div_done) begin
               keep_in = var_ff[axis_ff] - div_quo[VAR_BITS-1:0];
            end
         end
         ST_CEIL_DIV: begin
            if (div_done) begin
               sq_in = sq_ff - div_quo[SQ_BITS-1:0];
            end
         end
         ST_TERM_DIV: begin
            if (div_done) begin
               var_in[axis_ff] = (var_sum > {{(SQ_BITS+1-VAR_BITS){1'b0}}, VAR_MAX})
                                 ? VAR_MAX : var_sum[VAR_BITS-1:0];
               axis_in = (axis_ff == AXIS_BITS'(NUM_AXES - 1)) ? '0 : axis_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            axis_in  = '0;
            sum_in   = '0;
            grav_in  = '{default: '0};
            kind_in  = KIND_STATUS;
            multi_in = complete;
         end
         ST_NORM_MUL: begin
            if (mul_done) begin
               sum_in  = sum_ff + mul_prod[SQRT_X_BITS-1:0];
               axis_in = (axis_ff == AXIS_BITS'(NUM_ACC - 1)) ? '0 : axis_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               norm_in = sqrt_root;
               if (sqrt_root == '0) begin
                  finished_in = 1'b1;
               end
            end
         end
         ST_RATIO_DIV: begin
            if (div_done) begin
               ratio_in = div_quo[RATIO_BITS-1:0];
               axis_in  = '0;
            end
         end
         ST_GRAV_DIV: begin
            if (div_done) begin
               grav_in[axis_ff[1:0]] = mean_ff[axis_ff][WORD_BITS-1] ? gq : (~gq + 1'b1);
               axis_in = (axis_ff == AXIS_BITS'(NUM_ACC - 1)) ? '0 : axis_ff + 1'b1;
            end
         end
         ST_VAR_MUL1: begin
            if (mul_done) begin
               var_in[axis_ff] = round_sat(mul_prod);
            end
         end
         ST_VAR_MUL2: begin
            if (mul_done) begin
               var_in[axis_ff] = round_sat(mul_prod);
               if (axis_ff == AXIS_BITS'(NUM_ACC - 1)) begin
                  axis_in     = '0;
                  finished_in = 1'b1;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_count_in = count_ff;
               rsp_done_in  = finished_ff;
               rsp_last_in  = emit_last;
               kind_in      = kind_type'(kind_ff + 1'b1);
               case (kind_ff)
                  KIND_GRAVITY: begin
                     rsp_x_in = grav_ff[0];
                     rsp_y_in = grav_ff[1];
                     rsp_z_in = grav_ff[2];
                  end
                  KIND_BIAS: begin
                     rsp_x_in = mean_ff[3];
                     rsp_y_in = mean_ff[4];
                     rsp_z_in = mean_ff[5];
                  end
                  KIND_ACC_VAR: begin
                     rsp_x_in = {1'b0, var_ff[0]};
                     rsp_y_in = {1'b0, var_ff[1]};
                     rsp_z_in = {1'b0, var_ff[2]};
                  end
                  KIND_GYR_VAR: begin
                     rsp_x_in = {1'b0, var_ff[3]};
                     rsp_y_in = {1'b0, var_ff[4]};
                     rsp_z_in = {1'b0, var_ff[5]};
                  end
                  default: begin
                     rsp_x_in = '0;
                     rsp_y_in = '0;
                     rsp_z_in = '0;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         axis_ff      <= '0;
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         gravity_ff   <= GRAVITY_RESET;
         min_ff       <= MIN_COUNT_RESET;
         mean_ff      <= '{default: '0};
         var_ff       <= '{default: '0};
         kind_ff      <= KIND_STATUS;
         multi_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         axis_ff      <= axis_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         gravity_ff   <= gravity_in;
         min_ff       <= min_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         kind_ff      <= kind_in;
         multi_ff     <= multi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      frame_ff     <= frame_in;
      keep_ff      <= keep_in;
      sq_ff        <= sq_in;
      sum_ff       <= sum_in;
      norm_ff      <= norm_in;
      ratio_ff     <= ratio_in;
      grav_ff      <= grav_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_count_ff <= rsp_count_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_last_ff  <= rsp_last_in;
   end

   imu_sie_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   imu_sie_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   imu_sie_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vector_kind  = rsp_kind_ff;
   assign rsp_value_x      = rsp_x_ff;
   assign rsp_value_y      = rsp_y_ff;
   assign rsp_value_z      = rsp_z_ff;
   assign rsp_samples_seen = rsp_count_ff;
   assign rsp_init_done    = rsp_done_ff;
   assign rsp_last_of_run  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("Initialization flag was cleared after completion.");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("Sample count decreased.");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff <= AXIS_BITS'(NUM_AXES - 1))
      else $error("Axis index left its range.");

   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_init_done) |-> finished_ff)
      else $error("Result reports completion while the estimator is not finished.");
`endif

endmodule

// File: tb/tb_imu_static_init_estimator.sv
// Self-checking testbench of the IMU static initialization estimator with its own predictor.
module tb_imu_static_init_estimator;
   import imu_sie_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit            is_csr;
      logic          index;
      logic [23:0]   data;
      logic [31:0]   axis[6];
      logic          frame_end;
   } sample_entry_type;

   typedef struct {
      logic [2:0]    kind;
      logic [47:0]   x, y, z;
      logic [15:0]   count;
      logic          done;
      logic          last;
   } estimate_type;

   localparam longint unsigned VAR_LIMIT = (64'd1 << 47) - 1;
   localparam longint unsigned CNT_LIMIT = (64'd1 << COUNT_BITS) - 1;
   localparam int IDLE_LIMIT = 60000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready, req_frame_end = 1'b0;
   logic signed [31:0] req_acc_x = '0, req_acc_y = '0, req_acc_z = '0;
   logic signed [31:0] req_gyr_x = '0, req_gyr_y = '0, req_gyr_z = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [2:0] rsp_vector_kind;
   logic signed [47:0] rsp_value_x, rsp_value_y, rsp_value_z;
   logic [15:0] rsp_samples_seen;
   logic rsp_init_done, rsp_last_of_run;
   logic csr_valid = 1'b0, csr_ready, csr_index = 1'b0;
   logic [23:0] csr_data = '0;

   sample_entry_type pending_q[$];
   estimate_type     estimate_q[$];
   int               failures = 0;

   // Predictor state.
   longint unsigned p_gravity = 642908, p_min_count = 20, p_count = 0;
   longint          p_acc_mean[3], p_gyr_mean[3];
   longint unsigned p_acc_var[3], p_gyr_var[3];
   bit              p_finished = 0;

   always #4 clock = ~clock;

   imu_static_init_estimator i_dut (.*);

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint div_nearest(longint num, longint unsigned n);
      longint unsigned q;
      q = (magnitude(num) + n / 2) / n;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned square_q24(longint unsigned m);
      longint unsigned a, b;
      a = m >> 12;
      b = m & 64'hFFF;
      return a * a + ((((2 * a * b) << 12) + b * b) >> 24);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned variance_step(longint unsigned v, longint d,
                                                     longint unsigned n);
      longint unsigned sq, keep, term, s;
      sq = square_q24(magnitude(d));
      keep = v - (v + n - 1) / n;
      term = (sq - (sq + n - 1) / n) / n;
      s = keep + term;
      return s > VAR_LIMIT ? VAR_LIMIT : s;
   endfunction

   function automatic longint unsigned scale_sat(longint unsigned v, longint unsigned r);
      logic [127:0] p;
      p = 128'(v) * 128'(r);
      if (p > 128'(64'hFFFF_FFFF_FFFF_FFFF - 64'd32768)) return VAR_LIMIT;
      p = (p + 128'd32768) >> 16;
      return p > 128'(VAR_LIMIT) ? VAR_LIMIT : longint'(p[63:0]);
   endfunction

   task automatic push_estimate(kind_type kind, longint a, longint b, longint c, bit last);
      estimate_type e;
      e.kind = kind;
      e.x = a[47:0];
      e.y = b[47:0];
      e.z = c[47:0];
      e.count = p_count[15:0];
      e.done = p_finished;
      e.last = last;
      estimate_q = {estimate_q, e};
   endtask

   task automatic predict_sample(sample_entry_type s);
      longint cur_acc[3], cur_gyr[3], grav[3];
      longint unsigned n, norm, r, a, g;
      if (p_finished) begin
         push_estimate(KIND_STATUS, 0, 0, 0, 1);
         return;
      end
      for (int i = 0; i < 3; i++) begin
         cur_acc[i] = longint'($signed(s.axis[i])) * 256;
         cur_gyr[i] = longint'($signed(s.axis[3 + i])) * 256;
      end
      n = p_count < CNT_LIMIT ? p_count + 1 : CNT_LIMIT;
      p_count = n;
      for (int i = 0; i < 3; i++) begin
         p_acc_mean[i] += div_nearest(cur_acc[i] - p_acc_mean[i], n);
         p_gyr_mean[i] += div_nearest(cur_gyr[i] - p_gyr_mean[i], n);
         p_acc_var[i] = variance_step(p_acc_var[i], cur_acc[i] - p_acc_mean[i], n);
         p_gyr_var[i] = variance_step(p_gyr_var[i], cur_gyr[i] - p_gyr_mean[i], n);
      end
      if (!s.frame_end || !(p_count + 1 > p_min_count)) begin
         push_estimate(KIND_STATUS, 0, 0, 0, 1);
         return;
      end
      norm = 0;
      for (int i = 0; i < 3; i++) begin
         a = magnitude(p_acc_mean[i]) >> 8;
         norm += a * a;
         grav[i] = 0;
      end
      norm = int_sqrt(norm);
      if (norm != 0) begin
         r = ((p_gravity << 16) + norm / 2) / norm;
         for (int i = 0; i < 3; i++) begin
            g = (magnitude(p_acc_mean[i]) * p_gravity + norm / 2) / norm;
            grav[i] = p_acc_mean[i] < 0 ? longint'(g) : -longint'(g);
            p_acc_var[i] = scale_sat(scale_sat(p_acc_var[i], r), r);
         end
      end
      p_finished = 1;
      push_estimate(KIND_STATUS, 0, 0, 0, 0);
      push_estimate(KIND_GRAVITY, grav[0], grav[1], grav[2], 0);
      push_estimate(KIND_BIAS, p_gyr_mean[0], p_gyr_mean[1], p_gyr_mean[2], 0);
      push_estimate(KIND_ACC_VAR, p_acc_var[0], p_acc_var[1], p_acc_var[2], 0);
      push_estimate(KIND_GYR_VAR, p_gyr_var[0], p_gyr_var[1], p_gyr_var[2], 1);
   endtask

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h actual %h", name, exp_v, act_v);
         failures++;
      end
   endtask

   // Driver: sample and register transfers from the pending queue.
   int       send_gap = 0, send_count = 0;
   sample_entry_type head;
   always @(posedge clock) begin
      logic next_req, next_csr;
      if (!reset) begin
         next_req = req_valid;
         next_csr = csr_valid;
         if (req_valid && req_ready) begin
            next_req = 1'b0;
            predict_sample(head);
         end
         if (csr_valid && csr_ready) begin
            next_csr = 1'b0;
            if (csr_index == CSR_GRAVITY) p_gravity = csr_data;
            else p_min_count = csr_data[15:0];
         end
         if (!next_req && !next_csr) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_q.size() > 0) begin
               if (pending_q[0].is_csr) begin
                  if (estimate_q.size() == 0 && !req_valid) begin
                     head = pending_q.pop_front();
                     csr_index <= head.index;
                     csr_data <= head.data;
                     next_csr = 1'b1;
                  end
               end else begin
                  head = pending_q.pop_front();
                  req_acc_x <= head.axis[0];
                  req_acc_y <= head.axis[1];
                  req_acc_z <= head.axis[2];
                  req_gyr_x <= head.axis[3];
                  req_gyr_y <= head.axis[4];
                  req_gyr_z <= head.axis[5];
                  req_frame_end <= head.frame_end;
                  next_req = 1'b1;
                  send_count++;
                  send_gap = ((send_count / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
               end
            end
         end
         req_valid <= next_req;
         csr_valid <= next_csr;
      end
   end

   // Monitor: result checking, receiver stalls and the watchdog.
   int recv_stall = 0, recv_count = 0, idle_cycles = 0;
   always @(posedge clock) begin
      estimate_type e;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (estimate_q.size() == 0) begin
               $error("result transfer with no expected result");
               failures++;
            end else begin
               e = estimate_q.pop_front();
               check_field("vector_kind", e.kind, rsp_vector_kind);
               check_field("value_x", e.x, rsp_value_x[47:0]);
               check_field("value_y", e.y, rsp_value_y[47:0]);
               check_field("value_z", e.z, rsp_value_z[47:0]);
               check_field("samples_seen", e.count, rsp_samples_seen);
               check_field("init_done", e.done, rsp_init_done);
               check_field("last_of_run", e.last, rsp_last_of_run);
            end
            recv_count++;
            recv_stall = ((recv_count / 50) % 3 == 2) ? 0 : $urandom_range(0, 5);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic add_csr(logic index, logic [23:0] data);
      sample_entry_type s;
      s.is_csr = 1;
      s.index = index;
      s.data = data;
      pending_q = {pending_q, s};
   endtask

   task automatic add_sample(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                             logic [31:0] g0, logic [31:0] g1, logic [31:0] g2, logic fe);
      sample_entry_type s;
      s.is_csr = 0;
      s.axis = '{a0, a1, a2, g0, g1, g2};
      s.frame_end = fe;
      pending_q = {pending_q, s};
   endtask

   function automatic logic [31:0] random_axis(bit full, int center);
      if (full) return $urandom();
      return center + $urandom_range(0, 8192) - 4096;
   endfunction

   task automatic add_random(int count, int flag_one_in);
      int cx, cy, cz;
      bit full;
      cx = $urandom_range(0, 1310720) - 655360;
      cy = $urandom_range(0, 1310720) - 655360;
      cz = $urandom_range(0, 1310720) - 655360;
      for (int k = 0; k < count; k++) begin
         full = ($urandom_range(0, 9) == 0);
         add_sample(random_axis(full, cx), random_axis(full, cy), random_axis(full, cz),
                    random_axis(full, 300), random_axis(full, -200), random_axis(full, 0),
                    $urandom_range(1, flag_one_in) == 1);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Extremes with completion held off by the largest threshold.
      add_csr(CSR_GRAVITY, 24'd0);
      add_csr(CSR_MIN_COUNT, 24'd65535);
      add_sample('0, '0, '0, '0, '0, '0, 1'b1);
      add_sample('1, '1, '1, '1, '1, '1, 1'b0);
      add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000, 1'b0);
      add_sample(32'h0000_0000, 32'h0000_0000, 32'h0009_CF5C,
                 32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0000, 1'b1);
      add_sample(32'hFFF6_30A4, 32'h0000_0000, 32'h0000_0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);

      // Realistic data with a threshold reached partway through.
      add_csr(CSR_GRAVITY, 24'($urandom_range(500000, 700000)));
      add_csr(CSR_MIN_COUNT, 24'($urandom_range(60, 140)));
      add_random(150, 8);

      // Threshold of one and largest gravity, then samples after completion.
      add_csr(CSR_MIN_COUNT, 24'd1);
      add_csr(CSR_GRAVITY, 24'hFF_FFFF);
      add_random(120, 4);
      add_csr(CSR_MIN_COUNT, 24'($urandom_range(1, 65535)));
      add_random(30, 2);

      wait (pending_q.size() == 0 && !req_valid && !csr_valid && estimate_q.size() == 0);
      repeat (3000) @(posedge clock);
      if (failures == 0 && estimate_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
